@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sadu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sadu_pkg;

   localparam int unsigned DAY_BITS   = 8;
   localparam int unsigned TALLY_BITS = 17;
   localparam logic [TALLY_BITS-1:0] TALLY_LIMIT = 17'd65536;

   localparam logic [2:0] DS_SUSCEPTIBLE = 3'd0;
   localparam logic [2:0] DS_EXPOSED     = 3'd1;
   localparam logic [2:0] DS_INFECTIOUS  = 3'd2;
   localparam logic [2:0] DS_RECOVERED   = 3'd3;
   localparam logic [2:0] DS_DEAD        = 3'd4;

   localparam logic [1:0] VS_NONE   = 2'd0;
   localparam logic [1:0] VS_FIRST  = 2'd1;
   localparam logic [1:0] VS_SECOND = 2'd2;

   typedef struct packed {
      logic [2:0]          health_state;
      logic [1:0]          dose_state;
      logic [DAY_BITS-1:0] exposed_days_left;
      logic [DAY_BITS-1:0] sick_days_left;
      logic                fatal_mark;
      logic [DAY_BITS-1:0] dose_wait_days;
      logic                last_agent;
   } req_type;

   typedef struct packed {
      logic [2:0]            new_health_state;
      logic [DAY_BITS-1:0]   new_exposed_days;
      logic [DAY_BITS-1:0]   new_sick_days;
      logic [DAY_BITS-1:0]   new_dose_wait;
      logic                  tally_final;
      logic [TALLY_BITS-1:0] count_susceptible;
      logic [TALLY_BITS-1:0] count_exposed;
      logic [TALLY_BITS-1:0] count_infectious;
      logic [TALLY_BITS-1:0] count_recovered;
      logic [TALLY_BITS-1:0] count_dead;
      logic [TALLY_BITS-1:0] count_first_dose;
      logic [TALLY_BITS-1:0] count_second_dose;
   } rsp_type;

   typedef struct packed {
      logic susceptible;
      logic exposed;
      logic infectious;
      logic recovered;
      logic dead;
      logic first_dose;
      logic second_dose;
   } incr_type;

   typedef struct packed {
      logic [TALLY_BITS-1:0] susceptible;
      logic [TALLY_BITS-1:0] exposed;
      logic [TALLY_BITS-1:0] infectious;
      logic [TALLY_BITS-1:0] recovered;
      logic [TALLY_BITS-1:0] dead;
      logic [TALLY_BITS-1:0] first_dose;
      logic [TALLY_BITS-1:0] second_dose;
   } tally_type;

   function automatic logic [TALLY_BITS-1:0] bump(input logic [TALLY_BITS-1:0] t,
                                                  input logic en);
      return (en && (t < TALLY_LIMIT)) ? t + 17'd1 : t;
   endfunction

endpackage

`default_nettype wire

@@ rtl/sadu_tally.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sadu_tally (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire logic                clear,
   input  wire sadu_pkg::incr_type  incr,
   output sadu_pkg::tally_type      counts
);

   sadu_pkg::tally_type counts_ff;
   sadu_pkg::tally_type counts_in;
   sadu_pkg::tally_type bumped;

   always_comb begin
      bumped.susceptible = sadu_pkg::bump(counts_ff.susceptible, incr.susceptible);
      bumped.exposed     = sadu_pkg::bump(counts_ff.exposed, incr.exposed);
      bumped.infectious  = sadu_pkg::bump(counts_ff.infectious, incr.infectious);
      bumped.recovered   = sadu_pkg::bump(counts_ff.recovered, incr.recovered);
      bumped.dead        = sadu_pkg::bump(counts_ff.dead, incr.dead);
      bumped.first_dose  = sadu_pkg::bump(counts_ff.first_dose, incr.first_dose);
      bumped.second_dose = sadu_pkg::bump(counts_ff.second_dose, incr.second_dose);
   end

   // The tallies restart from zero once the last agent of a pass has been counted.
   always_comb begin
      counts_in = counts_ff;
      if (load) begin
         counts_in = clear ? '0 : bumped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff <= '0;
      end else begin
         counts_ff <= counts_in;
      end
   end

   assign counts = bumped;

endmodule

`default_nettype wire

@@ rtl/seird_agent_day_update.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One-day advance of an epidemic agent population, one agent record per transaction.
// Each record is captured in an input register, updated by shallow logic, and the
// updated record with the running S, E, I, R, D, V1 and V2 tallies is held in a
// result register, loaded from the input register unless a held result stalls; one
// record can be accepted in every cycle while the result side keeps up. The tallies
// saturate at 65536 and return to zero after the record marked last has been counted.

module seird_agent_day_update (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sadu_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sadu_pkg::rsp_type      rsp_data
);

   logic               s1_valid_ff;
   logic               s1_valid_in;
   sadu_pkg::req_type  s1_data_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   sadu_pkg::rsp_type  rsp_data_ff;
   sadu_pkg::rsp_type  rsp_data_in;
   logic               out_load;
   logic               req_take;
   sadu_pkg::incr_type incr;
   sadu_pkg::tally_type counts;
   logic [2:0]                   new_ds;
   logic [sadu_pkg::DAY_BITS-1:0] new_ed;
   logic [sadu_pkg::DAY_BITS-1:0] new_sd;
   logic [sadu_pkg::DAY_BITS-1:0] new_wait;

   assign out_load  = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      new_ds   = s1_data_ff.health_state;
      new_ed   = s1_data_ff.exposed_days_left;
      new_sd   = s1_data_ff.sick_days_left;
      new_wait = s1_data_ff.dose_wait_days;
      incr     = '0;
      case (s1_data_ff.health_state)
         sadu_pkg::DS_SUSCEPTIBLE: begin
            incr.susceptible = 1'b1;
         end
         sadu_pkg::DS_EXPOSED: begin
            if (s1_data_ff.exposed_days_left == '0) begin
               new_ds          = sadu_pkg::DS_INFECTIOUS;
               incr.infectious = 1'b1;
            end else begin
               new_ed       = s1_data_ff.exposed_days_left - 8'd1;
               incr.exposed = 1'b1;
            end
         end
         sadu_pkg::DS_INFECTIOUS: begin
            if (s1_data_ff.sick_days_left == '0) begin
               if (s1_data_ff.fatal_mark) begin
                  new_ds    = sadu_pkg::DS_DEAD;
                  incr.dead = 1'b1;
               end else begin
                  new_ds         = sadu_pkg::DS_RECOVERED;
                  incr.recovered = 1'b1;
               end
            end else begin
               new_sd          = s1_data_ff.sick_days_left - 8'd1;
               incr.infectious = 1'b1;
            end
         end
         sadu_pkg::DS_RECOVERED: begin
            incr.recovered = 1'b1;
         end
         sadu_pkg::DS_DEAD: begin
            incr.dead = 1'b1;
         end
         default: begin
         end
      endcase
      case (s1_data_ff.dose_state)
         sadu_pkg::VS_FIRST: begin
            incr.first_dose = 1'b1;
            if (s1_data_ff.dose_wait_days != '0) begin
               new_wait = s1_data_ff.dose_wait_days - 8'd1;
            end
         end
         sadu_pkg::VS_SECOND: begin
            incr.second_dose = 1'b1;
         end
         default: begin
         end
      endcase
   end

   sadu_tally u_tally (
      .clock  (clock),
      .reset  (reset),
      .load   (out_load),
      .clear  (s1_data_ff.last_agent),
      .incr   (incr),
      .counts (counts)
   );

   always_comb begin
      rsp_data_in.new_health_state   = new_ds;
      rsp_data_in.new_exposed_days   = new_ed;
      rsp_data_in.new_sick_days      = new_sd;
      rsp_data_in.new_dose_wait      = new_wait;
      rsp_data_in.tally_final        = s1_data_ff.last_agent;
      rsp_data_in.count_susceptible  = counts.susceptible;
      rsp_data_in.count_exposed      = counts.exposed;
      rsp_data_in.count_infectious   = counts.infectious;
      rsp_data_in.count_recovered    = counts.recovered;
      rsp_data_in.count_dead         = counts.dead;
      rsp_data_in.count_first_dose   = counts.first_dose;
      rsp_data_in.count_second_dose  = counts.second_dose;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/sadu_check.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sadu_check (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire sadu_pkg::rsp_type rsp_data
);

   logic rsp_take;
   logic [19:0] disease_sum;

   assign rsp_take = rsp_valid && !rsp_stall;
   assign disease_sum = 20'(rsp_data.count_susceptible) + 20'(rsp_data.count_exposed)
                      + 20'(rsp_data.count_infectious) + 20'(rsp_data.count_recovered)
                      + 20'(rsp_data.count_dead);

   // A stalled result transaction keeps its valid and its contents.
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp changed while stalled")

   `ASSERT_IMPLIES(a_tally_limit, rsp_valid,
      rsp_data.count_susceptible <= sadu_pkg::TALLY_LIMIT &&
      rsp_data.count_dead <= sadu_pkg::TALLY_LIMIT &&
      rsp_data.count_first_dose <= sadu_pkg::TALLY_LIMIT, "tally beyond its limit")

   // The first result after the end of a pass has counted at most one agent.
   `ASSERT_NEXT(a_pass_restart, rsp_take && rsp_data.tally_final,
      !rsp_valid || (disease_sum <= 20'd1 && rsp_data.count_second_dose <= 17'd1),
      "tallies not cleared after the last agent")

   `ASSERT_NEXT(a_tally_grows, rsp_take && !rsp_data.tally_final,
      !rsp_valid || (rsp_data.count_susceptible >= $past(rsp_data.count_susceptible) &&
      rsp_data.count_first_dose >= $past(rsp_data.count_first_dose)),
      "tally decreased within a pass")

   `ASSERT_IMPLIES(a_reset_idle, $past(reset), !rsp_valid, "result valid right after reset")

endmodule

bind seird_agent_day_update sadu_check u_sadu_check (.*);

`default_nettype wire

@@ verif/seird_agent_day_update_test.sv @@
`timescale 1ns / 1ps

module seird_agent_day_update_test;
   import sadu_pkg::*;

   localparam logic [2:0] DS_UNDEFINED_LOW  = 3'd5;
   localparam logic [2:0] DS_UNDEFINED_MID  = 3'd6;
   localparam logic [2:0] DS_UNDEFINED_HIGH = 3'd7;
   localparam logic [1:0] VS_UNDEFINED      = 2'd3;

   localparam int unsigned IDLE_PERCENT  = 24;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned RANDOM_AGENTS = 1670;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned DRAIN_LIMIT   = 2000;
   localparam int unsigned MAX_REPORTS   = 100;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   tally_type   day_tally = '0;
   rsp_type     expected_records[$];
   int unsigned mismatch_count  = 0;
   int unsigned agents_sent     = 0;
   int unsigned records_checked = 0;
   int unsigned passes_closed   = 0;
   bit          sender_idles    = 1'b0;
   bit          receiver_idles  = 1'b0;
   int unsigned hold_requests   = 0;
   int unsigned hold_served     = 0;
   int unsigned hold_left       = 0;

   seird_agent_day_update u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [TALLY_BITS-1:0] tally_inc(input logic [TALLY_BITS-1:0] count);
      return (count < TALLY_LIMIT) ? count + TALLY_BITS'(1) : count;
   endfunction

   function automatic rsp_type advance_agent(input req_type agent);
      rsp_type rec;
      rec = '0;
      rec.new_health_state   = agent.health_state;
      rec.new_exposed_days   = agent.exposed_days_left;
      rec.new_sick_days      = agent.sick_days_left;
      rec.new_dose_wait      = agent.dose_wait_days;
      rec.tally_final        = agent.last_agent;
      case (agent.health_state)
         DS_SUSCEPTIBLE: day_tally.susceptible = tally_inc(day_tally.susceptible);
         DS_EXPOSED: begin
            if (agent.exposed_days_left == '0) begin
               rec.new_health_state = DS_INFECTIOUS;
               day_tally.infectious = tally_inc(day_tally.infectious);
            end else begin
               rec.new_exposed_days = agent.exposed_days_left - DAY_BITS'(1);
               day_tally.exposed = tally_inc(day_tally.exposed);
            end
         end
         DS_INFECTIOUS: begin
            if (agent.sick_days_left != '0) begin
               rec.new_sick_days = agent.sick_days_left - DAY_BITS'(1);
               day_tally.infectious = tally_inc(day_tally.infectious);
            end else if (agent.fatal_mark) begin
               rec.new_health_state = DS_DEAD;
               day_tally.dead = tally_inc(day_tally.dead);
            end else begin
               rec.new_health_state = DS_RECOVERED;
               day_tally.recovered = tally_inc(day_tally.recovered);
            end
         end
         DS_RECOVERED: day_tally.recovered = tally_inc(day_tally.recovered);
         DS_DEAD: day_tally.dead = tally_inc(day_tally.dead);
         default: ;
      endcase
      case (agent.dose_state)
         VS_FIRST: begin
            day_tally.first_dose = tally_inc(day_tally.first_dose);
            if (agent.dose_wait_days != '0) begin
               rec.new_dose_wait = agent.dose_wait_days - DAY_BITS'(1);
            end
         end
         VS_SECOND: day_tally.second_dose = tally_inc(day_tally.second_dose);
         default: ;
      endcase
      rec.count_susceptible = day_tally.susceptible;
      rec.count_exposed     = day_tally.exposed;
      rec.count_infectious  = day_tally.infectious;
      rec.count_recovered   = day_tally.recovered;
      rec.count_dead        = day_tally.dead;
      rec.count_first_dose  = day_tally.first_dose;
      rec.count_second_dose = day_tally.second_dose;
      if (agent.last_agent) begin
         day_tally = '0;
      end
      return rec;
   endfunction

   function automatic req_type make_agent(input logic [2:0] status, input logic [1:0] vaccine,
                                          input logic [DAY_BITS-1:0] exposed,
                                          input logic [DAY_BITS-1:0] sick, input logic fatal,
                                          input logic [DAY_BITS-1:0] dose_wait,
                                          input logic last);
      req_type agent;
      agent.health_state      = status;
      agent.dose_state        = vaccine;
      agent.exposed_days_left = exposed;
      agent.sick_days_left    = sick;
      agent.fatal_mark        = fatal;
      agent.dose_wait_days    = dose_wait;
      agent.last_agent        = last;
      return agent;
   endfunction

   function automatic logic [DAY_BITS-1:0] random_days();
      if ($urandom_range(1) == 0) begin
         return DAY_BITS'($urandom_range(3));
      end
      return DAY_BITS'($urandom_range(255));
   endfunction

   function automatic req_type random_agent(input bit well_formed);
      req_type agent;
      agent.health_state      = well_formed ? 3'($urandom_range(4)) : 3'($urandom_range(7));
      agent.dose_state        = well_formed ? 2'($urandom_range(2)) : 2'($urandom_range(3));
      agent.exposed_days_left = random_days();
      agent.sick_days_left    = random_days();
      agent.fatal_mark        = 1'($urandom_range(1));
      agent.dose_wait_days    = random_days();
      agent.last_agent        = ($urandom_range(31) == 0);
      return agent;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS) begin
         $display("mismatch at %0t ns: %s", $time, what);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
      end
   endtask

   task automatic send_agent(input req_type agent);
      while (sender_idles && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= agent;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      expected_records.push_back(advance_agent(agent));
      agents_sent++;
      if (agent.last_agent) begin
         passes_closed++;
      end
   endtask

   task automatic wait_drained();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while ((expected_records.size() != 0) && (waited < DRAIN_LIMIT)) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= receiver_idles && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_records.size() == 0) begin
            report_mismatch("result transaction with no record outstanding");
         end else begin
            want = expected_records.pop_front();
            records_checked++;
            check_field("new_health_state", 32'(rsp_data.new_health_state),
                        32'(want.new_health_state));
            check_field("new_exposed_days", 32'(rsp_data.new_exposed_days),
                        32'(want.new_exposed_days));
            check_field("new_sick_days", 32'(rsp_data.new_sick_days),
                        32'(want.new_sick_days));
            check_field("new_dose_wait", 32'(rsp_data.new_dose_wait),
                        32'(want.new_dose_wait));
            check_field("tally_final", 32'(rsp_data.tally_final), 32'(want.tally_final));
            check_field("count_susceptible", 32'(rsp_data.count_susceptible),
                        32'(want.count_susceptible));
            check_field("count_exposed", 32'(rsp_data.count_exposed),
                        32'(want.count_exposed));
            check_field("count_infectious", 32'(rsp_data.count_infectious),
                        32'(want.count_infectious));
            check_field("count_recovered", 32'(rsp_data.count_recovered),
                        32'(want.count_recovered));
            check_field("count_dead", 32'(rsp_data.count_dead), 32'(want.count_dead));
            check_field("count_first_dose", 32'(rsp_data.count_first_dose),
                        32'(want.count_first_dose));
            check_field("count_second_dose", 32'(rsp_data.count_second_dose),
                        32'(want.count_second_dose));
         end
      end
   end

   task automatic test_directed();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      send_agent(make_agent(DS_SUSCEPTIBLE, VS_NONE, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0));
      send_agent(make_agent(DS_EXPOSED, VS_NONE, 8'd0, 8'd5, 1'b0, 8'd0, 1'b0));
      send_agent(make_agent(DS_EXPOSED, VS_NONE, 8'd1, 8'd0, 1'b1, 8'd0, 1'b0));
      send_agent(make_agent(DS_EXPOSED, VS_SECOND, 8'hFF, 8'hFF, 1'b0, 8'hFF, 1'b0));
      send_agent(make_agent(DS_INFECTIOUS, VS_NONE, 8'd3, 8'd0, 1'b0, 8'd0, 1'b0));
      send_agent(make_agent(DS_INFECTIOUS, VS_NONE, 8'd3, 8'd0, 1'b1, 8'd0, 1'b0));
      send_agent(make_agent(DS_INFECTIOUS, VS_FIRST, 8'd0, 8'hFF, 1'b1, 8'd9, 1'b0));
      send_agent(make_agent(DS_INFECTIOUS, VS_NONE, 8'd0, 8'd1, 1'b0, 8'd0, 1'b0));
      send_agent(make_agent(DS_RECOVERED, VS_NONE, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b0));
      send_agent(make_agent(DS_DEAD, VS_NONE, 8'hFF, 8'd0, 1'b1, 8'd0, 1'b0));
      send_agent(make_agent(DS_UNDEFINED_LOW, VS_FIRST, 8'd0, 8'd0, 1'b0, 8'd2, 1'b0));
      send_agent(make_agent(DS_UNDEFINED_MID, VS_SECOND, 8'd7, 8'd0, 1'b1, 8'd0, 1'b0));
      send_agent(make_agent(DS_UNDEFINED_HIGH, VS_NONE, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b0));
      send_agent(make_agent(DS_SUSCEPTIBLE, VS_FIRST, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0));
      send_agent(make_agent(DS_SUSCEPTIBLE, VS_FIRST, 8'd0, 8'd0, 1'b0, 8'd1, 1'b0));
      send_agent(make_agent(DS_SUSCEPTIBLE, VS_FIRST, 8'd0, 8'd0, 1'b0, 8'hFF, 1'b0));
      send_agent(make_agent(DS_SUSCEPTIBLE, VS_SECOND, 8'd0, 8'd0, 1'b0, 8'hFF, 1'b0));
      send_agent(make_agent(DS_SUSCEPTIBLE, VS_UNDEFINED, 8'd0, 8'd0, 1'b0, 8'd7, 1'b0));
      send_agent(make_agent(DS_UNDEFINED_HIGH, VS_UNDEFINED, 8'hFF, 8'hFF, 1'b1, 8'hFF,
                            1'b1));
      send_agent(make_agent(DS_EXPOSED, VS_FIRST, 8'd0, 8'd0, 1'b0, 8'd0, 1'b1));
      send_agent(make_agent(DS_DEAD, VS_SECOND, 8'd0, 8'd0, 1'b0, 8'd0, 1'b1));
      wait_drained();
   endtask

   task automatic test_backpressure();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      hold_requests++;
      repeat (60) send_agent(random_agent(1'b1));
      wait_drained();
   endtask

   task automatic test_random();
      int unsigned n;
      for (n = 0; n < RANDOM_AGENTS; n++) begin
         sender_idles   = !((n >= 700) && (n < 1000));
         receiver_idles = sender_idles;
         if ((n % 450) == 449) begin
            wait_drained();
         end
         send_agent(random_agent($urandom_range(9) != 0));
      end
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      if (expected_records.size() != 0) begin
         report_mismatch($sformatf("%0d records never returned", expected_records.size()));
      end
      $display("Sent %0d agent records over %0d closed passes and compared %0d results.",
               agents_sent, passes_closed, records_checked);
      $display("Covered every transition, undefined codes, pass boundaries, a long result");
      $display("stall, drain pauses and random passes with and without idle gaps.");
      if (mismatch_count == 0) begin
         $display("PASS seird_agent_day_update");
      end else begin
         $display("FAIL seird_agent_day_update");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAIL seird_agent_day_update");
      $finish;
   end

endmodule
